/* sv/tes_pkg.sv */
`default_nettype none
package tes_pkg;

	localparam int TreeBits = 6;
	localparam int NodeBits = 6;
	localparam int FeatBits = 5;
	localparam int MaxTrees = 64;
	localparam int FeatureCount = 32;
	localparam int MaxSteps = 1024;
	localparam int NodeAddrBits = TreeBits + NodeBits;
	localparam int NodeDepth = 1 << NodeAddrBits;

	localparam logic [1:0] MODE_NODE = 2'd0;
	localparam logic [1:0] MODE_WEIGHT = 2'd1;
	localparam logic [1:0] MODE_FEATURE = 2'd2;

	localparam logic [2:0] REG_USE_TREES = 3'd0;
	localparam logic [2:0] REG_TREE_COUNT = 3'd1;
	localparam logic [2:0] REG_BASE_SCORE = 3'd2;
	localparam logic [2:0] REG_LOGISTIC = 3'd3;
	localparam logic [2:0] REG_CLAMP = 3'd4;

	typedef struct packed {
		logic [1:0]          mode;
		logic [5:0]          tree_index;
		logic [5:0]          node_id;
		logic                is_leaf;
		logic [4:0]          feature_index;
		logic signed [31:0]  item_value;
		logic [5:0]          yes_child;
		logic [5:0]          no_child;
		logic [5:0]          missing_child;
		logic                present;
		logic                last;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] score;
		logic               tree_fault;
	} out_item_t;

	typedef struct packed {
		logic               valid;
		logic               leaf;
		logic [4:0]         feat;
		logic signed [31:0] value;
		logic [5:0]         yes;
		logic [5:0]         no;
		logic [5:0]         miss;
	} node_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_T_START,
		ST_T_ISSUE,
		ST_T_NODE,
		ST_T_CMP,
		ST_L_RD,
		ST_L_MUL,
		ST_L_ACC,
		ST_FIN
	} state_t;

	function automatic logic [15:0] sig_tab(input logic [5:0] k);
		logic [15:0] r;
		case (k)
			6'd0: r = 16'd32768;  6'd1: r = 16'd36843;  6'd2: r = 16'd40793;
			6'd3: r = 16'd44511;  6'd4: r = 16'd47911;  6'd5: r = 16'd50941;
			6'd6: r = 16'd53581;  6'd7: r = 16'd55834;  6'd8: r = 16'd57724;
			6'd9: r = 16'd59287;  6'd10: r = 16'd60565; 6'd11: r = 16'd61598;
			6'd12: r = 16'd62428; 6'd13: r = 16'd63090; 6'd14: r = 16'd63615;
			6'd15: r = 16'd64030; 6'd16: r = 16'd64357; 6'd17: r = 16'd64614;
			6'd18: r = 16'd64816; 6'd19: r = 16'd64974; 6'd20: r = 16'd65097;
			6'd21: r = 16'd65194; 6'd22: r = 16'd65269; 6'd23: r = 16'd65328;
			6'd24: r = 16'd65374; 6'd25: r = 16'd65410; 6'd26: r = 16'd65438;
			6'd27: r = 16'd65459; 6'd28: r = 16'd65476; 6'd29: r = 16'd65489;
			6'd30: r = 16'd65500; 6'd31: r = 16'd65508; 6'd32: r = 16'd65514;
			default: r = 16'd65514;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

/* sv/tes_if.sv */
`default_nettype none
interface tes_in_if;
	logic                valid;
	logic                ready;
	tes_pkg::in_item_t   data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface tes_out_if;
	logic                valid;
	logic                ready;
	tes_pkg::out_item_t  data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface tes_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [31:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* sv/tes_ram.sv */
`default_nettype none
module tes_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

/* sv/tree_ensemble_scorer_top.sv */
`default_nettype none
// tree ensemble / linear scorer. input requests are node loads, weight loads and
// feature writes, taken only while the block is idle. a feature
// request with last set starts scoring and yields one result request. tree mode
// handles each visited node as a node memory read, then a decision, and when the
// node's feature is present a feature memory read, then a compare; linear mode
// steps through each feature as memory read, 32x32 multiply, accumulate. after
// reset the node memory is swept clear, one entry a cycle, over all 4096 entries,
// during which input requests are held off; configuration writes are always
// taken. a finished score sits in an output register while new loads go on.
module tree_ensemble_scorer_top (
	input  wire logic  clk,
	input  wire logic  arst_n,
	tes_in_if.sink     in_ch,
	tes_out_if.source  out_ch,
	tes_cfg_if.sink    cfg
);
	import tes_pkg::*;

	// configuration registers
	logic               use_trees_q;
	logic [6:0]         tree_count_q;
	logic signed [31:0] base_score_q;
	logic               logistic_q;
	logic               clamp_q;

	state_t state_q, state_d;

	logic [NodeAddrBits-1:0] clr_q;
	logic [6:0]              t_q;
	logic [5:0]              node_q;
	logic [10:0]             step_q;
	logic [5:0]              f_q;
	logic signed [55:0]      sum_q;
	logic                    fault_q;
	node_t                   nd_q;
	logic signed [63:0]      prod_q;
	logic                    pres_q;
	logic [FeatureCount-1:0] fp_q;
	logic [FeatureCount-1:0] wv_q;
	logic                    out_valid_q;
	out_item_t               out_q;

	// memories
	logic                    nd_we;
	logic [NodeAddrBits-1:0] nd_waddr;
	node_t                   nd_wdata, nd_rdata;
	logic [56:0]             nd_rraw;
	logic                    fv_we, w_we;
	logic [4:0]              fv_raddr;
	logic signed [31:0]      fv_rdata, w_rdata;

	logic     in_acc;
	in_item_t it;
	logic     out_free;
	logic [6:0] n_trees;
	logic signed [31:0] result;

	assign it       = in_ch.data;
	assign in_ch.ready = (state_q == ST_IDLE);
	assign in_acc   = in_ch.valid && in_ch.ready;
	assign cfg.ready = 1'b1;
	assign out_free = !out_valid_q || out_ch.ready;
	assign out_ch.valid = out_valid_q;
	assign out_ch.data  = out_q;
	assign n_trees  = (tree_count_q > 7'(MaxTrees)) ? 7'(MaxTrees) : tree_count_q;

	// node writes: clearing sweep or node load requests
	always_comb begin
		nd_we    = 1'b0;
		nd_waddr = clr_q;
		nd_wdata = '0;
		if (state_q == ST_CLEAR) begin
			nd_we = 1'b1;
		end else if (in_acc && it.mode == MODE_NODE) begin
			nd_we    = 1'b1;
			nd_waddr = {it.tree_index, it.node_id};
			nd_wdata = '{valid: 1'b1, leaf: it.is_leaf, feat: it.feature_index,
				value: it.item_value, yes: it.yes_child, no: it.no_child,
				miss: it.missing_child};
		end
	end

	assign nd_rdata = node_t'(nd_rraw);
	assign fv_we = in_acc && it.mode == MODE_FEATURE;
	assign w_we  = in_acc && it.mode == MODE_WEIGHT;
	assign fv_raddr = (state_q == ST_T_NODE) ? nd_rdata.feat : f_q[4:0];

	tes_ram #(.WIDTH(57), .DEPTH(NodeDepth)) u_node_ram (
		.clk(clk), .we(nd_we), .waddr(nd_waddr), .wdata(57'(nd_wdata)),
		.raddr({t_q[5:0], node_q}), .rdata(nd_rraw)
	);

	tes_ram #(.WIDTH(32), .DEPTH(FeatureCount)) u_feat_ram (
		.clk(clk), .we(fv_we), .waddr(it.feature_index), .wdata(it.item_value),
		.raddr(fv_raddr), .rdata(fv_rdata)
	);

	tes_ram #(.WIDTH(32), .DEPTH(FeatureCount)) u_weight_ram (
		.clk(clk), .we(w_we), .waddr(it.feature_index), .wdata(it.item_value),
		.raddr(f_q[4:0]), .rdata(w_rdata)
	);

	// final score from the exact sum
	always_comb begin
		logic signed [55:0] a;
		logic [15:0] y, lo, hi;
		logic [29:0] p;
		logic signed [55:0] s;
		a  = sum_q[55] ? -sum_q : sum_q;
		lo = sig_tab({1'b0, a[18:14]});
		hi = sig_tab({1'b0, a[18:14]} + 6'd1);
		p  = 30'(hi - lo) * 30'(a[13:0]);
		if (a >= 56'sd524288) begin
			y = sig_tab(6'd32);
		end else begin
			y = lo + 16'(p >> 14);
		end
		s = sum_q;
		if (!use_trees_q && clamp_q) begin
			if (s < 0) s = '0;
			if (s > 56'sd65536) s = 56'sd65536;
		end
		if (use_trees_q && logistic_q) begin
			result = sum_q[55] ? (32'sd65536 - 32'(y)) : 32'(y);
		end else if (s > 56'sd2147483647) begin
			result = 32'sh7fffffff;
		end else if (s < -56'sd2147483648) begin
			result = 32'sh80000000;
		end else begin
			result = s[31:0];
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: if (clr_q == NodeAddrBits'(NodeDepth - 1)) state_d = ST_IDLE;
			ST_IDLE: begin
				if (in_acc && it.mode == MODE_FEATURE && it.last) begin
					state_d = use_trees_q ? ST_T_START : ST_L_RD;
				end
			end
			ST_T_START: state_d = (t_q == n_trees) ? ST_FIN : ST_T_ISSUE;
			ST_T_ISSUE: state_d = ST_T_NODE;
			ST_T_NODE: begin
				if (step_q == 11'(MaxSteps) || !nd_rdata.valid || nd_rdata.leaf) begin
					state_d = ST_T_START;
				end else if (fp_q[nd_rdata.feat]) begin
					state_d = ST_T_CMP;
				end else begin
					state_d = ST_T_ISSUE;
				end
			end
			ST_T_CMP: state_d = ST_T_ISSUE;
			ST_L_RD: state_d = (f_q == 6'(FeatureCount)) ? ST_FIN : ST_L_MUL;
			ST_L_MUL: state_d = ST_L_ACC;
			ST_L_ACC: state_d = ST_L_RD;
			ST_FIN: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// datapath and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_trees_q  <= 1'b0;
			tree_count_q <= '0;
			base_score_q <= '0;
			logistic_q   <= 1'b0;
			clamp_q      <= 1'b1;
			clr_q        <= '0;
			fp_q         <= '0;
			wv_q         <= '0;
			out_valid_q  <= 1'b0;
			out_q        <= '0;
			t_q          <= '0;
			node_q       <= '0;
			step_q       <= '0;
			f_q          <= '0;
			sum_q        <= '0;
			nd_q         <= '0;
			prod_q       <= '0;
			pres_q       <= 1'b0;
			fault_q      <= 1'b0;
		end else begin
			if (cfg.valid) begin
				case (cfg.index)
					REG_USE_TREES:  use_trees_q  <= cfg.data[0];
					REG_TREE_COUNT: tree_count_q <= cfg.data[6:0];
					REG_BASE_SCORE: base_score_q <= cfg.data;
					REG_LOGISTIC:   logistic_q   <= cfg.data[0];
					REG_CLAMP:      clamp_q      <= cfg.data[0];
					default: ;
				endcase
			end
			if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
			// result register: load on finish, drop once taken
			if (state_q == ST_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			if (w_we) wv_q[it.feature_index] <= 1'b1;
			if (fv_we) fp_q[it.feature_index] <= it.present;

			case (state_q)
				ST_IDLE: begin
					// scoring start: seed the accumulator
					sum_q   <= 56'(base_score_q);
					fault_q <= 1'b0;
					t_q     <= '0;
					f_q     <= '0;
					node_q  <= '0;
					step_q  <= '0;
				end
				ST_T_NODE: begin
					nd_q <= nd_rdata;
					if (step_q == 11'(MaxSteps) || !nd_rdata.valid) begin
						// broken walk: tree gives zero
						fault_q <= 1'b1;
						t_q <= t_q + 1'b1; node_q <= '0; step_q <= '0;
					end else if (nd_rdata.leaf) begin
						sum_q <= sum_q + 56'(nd_rdata.value);
						t_q <= t_q + 1'b1; node_q <= '0; step_q <= '0;
					end else if (!fp_q[nd_rdata.feat]) begin
						node_q <= nd_rdata.miss;
						step_q <= step_q + 1'b1;
					end
				end
				ST_T_CMP: begin
					node_q <= (fv_rdata < nd_q.value) ? nd_q.yes : nd_q.no;
					step_q <= step_q + 1'b1;
				end
				ST_L_MUL: begin
					prod_q <= 64'(fv_rdata) * (wv_q[f_q[4:0]] ? 64'(w_rdata) : 64'sd0);
					pres_q <= fp_q[f_q[4:0]];
				end
				ST_L_ACC: begin
					if (pres_q) sum_q <= sum_q + 56'(prod_q >>> 16);
					f_q <= f_q + 1'b1;
				end
				ST_FIN: begin
					if (out_free) begin
						out_q.score <= result;
						out_q.tree_fault <= use_trees_q && fault_q;
					end
				end
				default: ;
			endcase
		end
	end
endmodule
`default_nettype wire

/* tb/tree_ensemble_scorer_top_test.sv */
`default_nettype none
module tree_ensemble_scorer_top_test;
	import tes_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int StallLimit = 300000;
	localparam logic [1:0] ModeUnused = 2'd3;

	// sigmoid of k/4 for k = 0..32, q16.16
	localparam longint LogisticTab [0:32] = '{
		32768, 36843, 40793, 44511, 47911, 50941, 53581, 55834,
		57724, 59287, 60565, 61598, 62428, 63090, 63615, 64030,
		64357, 64614, 64816, 64974, 65097, 65194, 65269, 65328,
		65374, 65410, 65438, 65459, 65476, 65489, 65500, 65508,
		65514
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	tes_in_if  in_ch ();
	tes_out_if out_ch ();
	tes_cfg_if cfg ();

	tree_ensemble_scorer_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg    (cfg)
	);

	always #5 clk = ~clk;

	// shadow copy of the block's registers and memories
	logic        m_use_trees;
	logic [6:0]  m_tree_count;
	longint      m_base;
	logic        m_logistic;
	logic        m_clamp;
	node_t       m_nodes [NodeDepth];
	longint      m_weights [FeatureCount];
	longint      m_fvals [FeatureCount];
	logic        m_fpres [FeatureCount];

	in_item_t    pending_requests [$];
	out_item_t   score_q [$];
	int          errors = 0;
	bit          sender_idles = 1'b1;
	bit          receiver_stalls = 1'b1;
	int          send_gap = 0;
	int          recv_stall = 0;
	int          quiet_cycles = 0;

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		errors++;
	endtask

	task automatic queue_request(input in_item_t it);
		pending_requests = {pending_requests, it};
	endtask

	function automatic int draw_wait(input bit enabled);
		return enabled ? int'($urandom_range(0, 9)) : 0;
	endfunction

	// walk one tree from its root; faulted trees give zero
	function automatic longint walk_tree(input int t, inout bit fault);
		int node;
		node_t nd;
		node = 0;
		for (int step = 0; step < MaxSteps; step++) begin
			nd = m_nodes[t * 64 + node];
			if (!nd.valid)
				break;
			if (nd.leaf)
				return longint'(nd.value);
			if (!m_fpres[nd.feat])
				node = int'(nd.miss);
			else if (m_fvals[nd.feat] < longint'(nd.value))
				node = int'(nd.yes);
			else
				node = int'(nd.no);
		end
		fault = 1'b1;
		return 0;
	endfunction

	function automatic longint sat32(input longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint logistic_q16(input longint x);
		longint a, y, frac;
		int idx;
		a = x < 0 ? -x : x;
		if (a >= (longint'(8) << 16)) begin
			y = LogisticTab[32];
		end else begin
			idx = int'(a >> 14);
			frac = a & 64'h3fff;
			y = LogisticTab[idx] + (((LogisticTab[idx + 1] - LogisticTab[idx]) * frac) >>> 14);
		end
		return x < 0 ? 65536 - y : y;
	endfunction

	function automatic out_item_t score_vector();
		out_item_t r;
		longint sum;
		bit fault;
		int n;
		fault = 1'b0;
		sum = m_base;
		if (m_use_trees) begin
			n = m_tree_count > MaxTrees ? MaxTrees : int'(m_tree_count);
			for (int t = 0; t < n; t++)
				sum += walk_tree(t, fault);
			sum = m_logistic ? logistic_q16(sum) : sat32(sum);
		end else begin
			for (int f = 0; f < FeatureCount; f++)
				if (m_fpres[f])
					sum += (m_fvals[f] * m_weights[f]) >>> 16;
			if (m_clamp) begin
				if (sum < 0)
					sum = 0;
				if (sum > 65536)
					sum = 65536;
			end
			sum = sat32(sum);
		end
		r.score = sum[31:0];
		r.tree_fault = fault;
		return r;
	endfunction

	// apply one accepted request to the shadow state
	task automatic apply_request(input in_item_t it);
		case (it.mode)
			MODE_NODE: begin
				m_nodes[{it.tree_index, it.node_id}] = '{valid: 1'b1, leaf: it.is_leaf,
					feat: it.feature_index, value: it.item_value, yes: it.yes_child,
					no: it.no_child, miss: it.missing_child};
			end
			MODE_WEIGHT: m_weights[it.feature_index] = longint'(it.item_value);
			MODE_FEATURE: begin
				m_fvals[it.feature_index] = longint'(it.item_value);
				m_fpres[it.feature_index] = it.present;
				if (it.last)
					score_q = {score_q, score_vector()};
			end
			default: ;
		endcase
	endtask

	// request driver, one gap drawn per request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.data <= '0;
			send_gap <= 0;
		end else if (!in_ch.valid || in_ch.ready) begin
			if (send_gap != 0) begin
				in_ch.valid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (pending_requests.size() != 0) begin
				in_ch.data <= pending_requests.pop_front();
				in_ch.valid <= 1'b1;
				send_gap <= draw_wait(sender_idles);
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// result side back-pressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			recv_stall <= 0;
		end else if (out_ch.valid && out_ch.ready) begin
			int s;
			s = draw_wait(receiver_stalls);
			recv_stall <= s;
			out_ch.ready <= (s == 0);
		end else if (recv_stall != 0) begin
			recv_stall <= recv_stall - 1;
			out_ch.ready <= (recv_stall == 1);
		end else begin
			out_ch.ready <= 1'b1;
		end
	end

	// monitor: track config writes, predict on requests, check results
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_USE_TREES: m_use_trees = cfg.data[0];
					REG_TREE_COUNT: m_tree_count = cfg.data[6:0];
					REG_BASE_SCORE: m_base = longint'($signed(cfg.data));
					REG_LOGISTIC: m_logistic = cfg.data[0];
					REG_CLAMP: m_clamp = cfg.data[0];
					default: ;
				endcase
			end
			if (in_ch.valid && in_ch.ready)
				apply_request(in_ch.data);
			if (out_ch.valid && out_ch.ready) begin
				if (score_q.size() == 0) begin
					report_mismatch("result with nothing expected");
				end else begin
					out_item_t exp_r;
					exp_r = score_q.pop_front();
					if (out_ch.data.score !== exp_r.score)
						report_mismatch($sformatf("score %h, expected %h",
							out_ch.data.score, exp_r.score));
					if (out_ch.data.tree_fault !== exp_r.tree_fault)
						report_mismatch($sformatf("tree_fault %b, expected %b",
							out_ch.data.tree_fault, exp_r.tree_fault));
				end
			end
		end
	end

	// watchdog on cycles with no handshake at all
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
				|| (cfg.valid && cfg.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= StallLimit) begin
			$display("tb: failure");
			$finish;
		end
	end

	function automatic in_item_t rand_bits();
		logic [95:0] r;
		r = {$urandom(), $urandom(), $urandom()};
		return r[$bits(in_item_t)-1:0];
	endfunction

	// q16.16 values: extremes, full random, or near zero
	function automatic logic [31:0] rand_q16();
		case ($urandom_range(0, 5))
			0: return $urandom();
			1: return 32'h7fffffff;
			2: return 32'h80000000;
			default: return $urandom_range(0, 32'h60000) - 32'h30000;
		endcase
	endfunction

	function automatic in_item_t node_request(input int t, input int n, input bit leaf,
			input int f, input logic [31:0] v, input int y, input int no, input int m);
		in_item_t it;
		it = rand_bits();
		it.mode = MODE_NODE;
		it.tree_index = 6'(t);
		it.node_id = 6'(n);
		it.is_leaf = leaf;
		it.feature_index = 5'(f);
		it.item_value = v;
		it.yes_child = 6'(y);
		it.no_child = 6'(no);
		it.missing_child = 6'(m);
		return it;
	endfunction

	function automatic in_item_t feature_request(input int f, input logic [31:0] v,
			input bit pres, input bit last);
		in_item_t it;
		it = rand_bits();
		it.mode = MODE_FEATURE;
		it.feature_index = 5'(f);
		it.item_value = v;
		it.present = pres;
		it.last = last;
		return it;
	endfunction

	// one write, then valid is dropped low before returning
	task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
		cfg.index <= idx;
		cfg.data <= value;
		cfg.valid <= 1'b1;
		do
			@(posedge clk);
		while (!cfg.ready);
		cfg.valid <= 1'b0;
		@(posedge clk);
	endtask

	// everything sent and scored, then a short wait for a trailing load
	task automatic drain();
		while (pending_requests.size() != 0 || in_ch.valid || score_q.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	// child pointer: mostly forward into the tree, now and then an unwritten node
	function automatic int pick_child(input int i, input int n);
		if ($urandom_range(0, 29) == 0)
			return 63;
		return $urandom_range(i + 1, n - 1);
	endfunction

	task automatic build_tree(input int t);
		int n;
		n = $urandom_range(1, 8);
		for (int i = 0; i < n; i++) begin
			if (i == n - 1 || $urandom_range(0, 3) == 0)
				queue_request(node_request(t, i, 1'b1, $urandom_range(0, 31),
					rand_q16(), $urandom_range(0, 63), $urandom_range(0, 63),
					$urandom_range(0, 63)));
			else
				queue_request(node_request(t, i, 1'b0,
					$urandom_range(0, 3) == 0 ? $urandom_range(0, 31) : $urandom_range(0, 7),
					rand_q16(), pick_child(i, n), pick_child(i, n), pick_child(i, n)));
		end
	endtask

	// a feature vector ending in a scoring request, with some noise
	task automatic queue_vector();
		int k;
		in_item_t it;
		k = $urandom_range(1, 6);
		for (int i = 0; i < k; i++) begin
			if ($urandom_range(0, 19) == 0) begin
				it = rand_bits();
				it.mode = ModeUnused;
				queue_request(it);
			end
			queue_request(feature_request(
				$urandom_range(0, 3) == 0 ? $urandom_range(0, 31) : $urandom_range(0, 7),
				rand_q16(), $urandom_range(0, 4) != 0, i == k - 1));
		end
	endtask

	initial begin
		in_item_t it;
		int base_count;
		cfg.valid <= 1'b0;
		cfg.index <= '0;
		cfg.data <= '0;
		m_use_trees = 1'b0;
		m_tree_count = '0;
		m_base = 0;
		m_logistic = 1'b0;
		m_clamp = 1'b1;
		foreach (m_nodes[i])
			m_nodes[i] = '0;
		foreach (m_weights[i]) begin
			m_weights[i] = 0;
			m_fvals[i] = 0;
			m_fpres[i] = 1'b0;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part: one split tree, a dangling link, a loop
		sender_idles = 1'b0;
		receiver_stalls = 1'b0;
		write_reg(REG_USE_TREES, 32'd1);
		write_reg(REG_TREE_COUNT, 32'd3);
		write_reg(REG_BASE_SCORE, 32'd0);
		write_reg(REG_LOGISTIC, 32'd0);
		write_reg(REG_CLAMP, 32'd1);
		it = '1;
		queue_request(it);  // mode three, ignored
		queue_request(node_request(0, 0, 1'b0, 3, 32'd0, 1, 2, 3));
		queue_request(node_request(0, 1, 1'b1, 31, 32'h7fffffff, 63, 63, 63));
		queue_request(node_request(0, 2, 1'b1, 0, 32'h80000000, 0, 0, 0));
		queue_request(node_request(0, 3, 1'b1, 0, 32'h00050000, 0, 0, 0));
		queue_request(node_request(1, 0, 1'b0, 0, 32'd0, 40, 40, 40));
		queue_request(node_request(2, 0, 1'b0, 0, 32'd0, 0, 0, 0));
		queue_request(feature_request(3, 32'hffffffff, 1'b1, 1'b1));
		queue_request(feature_request(3, 32'd0, 1'b1, 1'b1));
		queue_request(feature_request(3, 32'h7fffffff, 1'b0, 1'b1));
		queue_request(feature_request(31, 32'h80000000, 1'b1, 1'b0));
		queue_request(feature_request(0, 32'h7fffffff, 1'b1, 1'b1));
		// retire the loop so later vectors stay quick
		queue_request(node_request(2, 0, 1'b1, 0, 32'h00010000, 0, 0, 0));
		drain();

		// random phases, each with its own register setting
		for (int p = 0; p < 12; p++) begin
			sender_idles = (p % 4) != 1;
			receiver_stalls = (p % 4) != 2;
			case (p)
				0: begin
					write_reg(REG_USE_TREES, 32'd1);
					write_reg(REG_TREE_COUNT, 32'd64);
					write_reg(REG_BASE_SCORE, 32'h7fffffff);
					write_reg(REG_LOGISTIC, 32'd1);
				end
				1: begin
					write_reg(REG_TREE_COUNT, 32'd127);
					write_reg(REG_BASE_SCORE, 32'h80000000);
					write_reg(REG_LOGISTIC, 32'd0);
				end
				2: begin
					write_reg(REG_USE_TREES, 32'd0);
					write_reg(REG_CLAMP, 32'd0);
					write_reg(REG_BASE_SCORE, 32'h80000000);
				end
				3: begin
					write_reg(REG_CLAMP, 32'd1);
					write_reg(REG_BASE_SCORE, 32'h7fffffff);
				end
				4: begin
					write_reg(REG_USE_TREES, 32'd1);
					write_reg(REG_TREE_COUNT, 32'd0);
					write_reg(REG_BASE_SCORE, rand_q16());
				end
				default: begin
					write_reg(REG_USE_TREES, $urandom_range(0, 1));
					write_reg(REG_TREE_COUNT, $urandom_range(0, 3) == 0 ?
						$urandom_range(0, 127) : $urandom_range(1, 12));
					write_reg(REG_BASE_SCORE, rand_q16());
					write_reg(REG_LOGISTIC, $urandom_range(0, 1));
					write_reg(REG_CLAMP, $urandom_range(0, 1));
				end
			endcase
			base_count = pending_requests.size();
			repeat (3) build_tree($urandom_range(0, 15));
			repeat (8) begin
				it = rand_bits();
				it.mode = MODE_WEIGHT;
				it.item_value = rand_q16();
				queue_request(it);
			end
			while (pending_requests.size() - base_count < 110)
				queue_vector();
			drain();
		end

		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
`default_nettype wire

/* filelist.f */
sv/tes_pkg.sv
sv/tes_if.sv
sv/tes_ram.sv
sv/tree_ensemble_scorer_top.sv
tb/tree_ensemble_scorer_top_test.sv
